FILE: hdl/twlc_pkg.sv
// Shared types, constants and helpers for the whitespace and line cleaner.
`default_nettype none
package twlc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned POS_W     = 13;
  localparam int unsigned BYTE_W    = 8;
  // Output buffer depth; the effective limit never exceeds it
  localparam int unsigned OUT_DEPTH = 4096;
  // Most writes a single byte can cause: run flush plus four terminator zeros
  localparam int unsigned MAX_RES   = 5;
  localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_RES);
  // Extra terminator zeros are written only if pos + TAIL_GAP < limit
  localparam int unsigned TAIL_GAP  = 5;
  localparam int unsigned TAIL_CNT  = 4;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  // One addressed write into the output buffer
  typedef struct packed {
    logic [POS_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
    logic              done;
    logic [POS_W-1:0]  len;
  } res_t;

  // All writes caused by one byte
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    res_t [MAX_RES-1:0]        res;
  } batch_t;

  // Per-text scanning state
  typedef struct packed {
    logic [POS_W-1:0] out_pos;
    logic [POS_W-1:0] line_mark;
    logic             line_blank;
    logic             prev_line_blank;
    logic             line_has_letter;
    logic             in_space_run;
    logic             run_has_tab;
    logic             halted;
  } state_t;

  localparam state_t STATE_RST = '{
    out_pos:         '0,
    line_mark:       '0,
    line_blank:      1'b1,
    prev_line_blank: 1'b1,
    line_has_letter: 1'b0,
    in_space_run:    1'b0,
    run_has_tab:     1'b0,
    halted:          1'b0
  };

  function automatic res_t mk_res(logic [POS_W-1:0] addr, logic [BYTE_W-1:0] data,
                                  logic done, logic [POS_W-1:0] len);
    res_t r;
    r.addr = addr;
    r.data = data;
    r.done = done;
    r.len  = len;
    return r;
  endfunction

  function automatic logic is_letter(logic [BYTE_W-1:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

endpackage
`default_nettype wire

FILE: hdl/twlc_step.sv
// Scanning state and the single-pass logic that turns one byte into its writes.
`default_nettype none
module twlc_step (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [twlc_pkg::BYTE_W-1:0]   byte_i,
  input  wire logic [twlc_pkg::POS_W-1:0]    limit_i,
  input  wire logic                          load_i,
  output twlc_pkg::batch_t                   batch_o
);

  twlc_pkg::state_t st_q, st_d;

  // State advances once per byte handed to the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= twlc_pkg::STATE_RST;
    end else if (load_i) begin
      st_q <= st_d;
    end
  end

  // Next state and the list of writes for the current byte
  always_comb begin
    twlc_pkg::batch_t             bat;
    logic [twlc_pkg::CNT_W-1:0]   n;
    logic [twlc_pkg::POS_W-1:0]   pos;
    logic [twlc_pkg::POS_W-1:0]   tpos;
    logic [twlc_pkg::POS_W-1:0]   p;
    logic [twlc_pkg::BYTE_W-1:0]  fch;
    logic                         ws;
    logic                         fw;
    logic                         do_take;
    logic                         lb;
    logic                         tail;

    st_d    = st_q;
    bat     = '0;
    n       = '0;
    pos     = st_q.out_pos;
    tpos    = st_q.out_pos;
    p       = st_q.out_pos;
    ws      = (byte_i == twlc_pkg::CH_SPACE) || (byte_i == twlc_pkg::CH_TAB);
    fw      = st_q.run_has_tab || !st_q.line_blank;
    fch     = st_q.run_has_tab ? twlc_pkg::CH_TAB : twlc_pkg::CH_SPACE;
    do_take = 1'b0;
    lb      = st_q.line_blank;
    tail    = 1'b0;

    if (byte_i == twlc_pkg::CH_NUL) begin
      // End of text: flush a pending run, then the terminator zeros
      if (st_q.in_space_run && !st_q.halted && fw) begin
        bat.res[0] = twlc_pkg::mk_res(pos, fch, 1'b0, '0);
        n          = twlc_pkg::CNT_W'(1);
        pos        = pos + twlc_pkg::POS_W'(1);
      end
      tail = ({1'b0, pos} + (twlc_pkg::POS_W + 1)'(twlc_pkg::TAIL_GAP)) < {1'b0, limit_i};
      for (int k = 0; k < twlc_pkg::TAIL_CNT; k++) begin
        if (k == 0 || tail) begin
          bat.res[n] = twlc_pkg::mk_res(pos + twlc_pkg::POS_W'(k), twlc_pkg::CH_NUL,
                                        1'b1, pos);
          n          = n + twlc_pkg::CNT_W'(1);
        end
      end
      st_d = twlc_pkg::STATE_RST;
    end else if (!st_q.halted) begin
      if (st_q.in_space_run) begin
        if (ws) begin
          st_d.run_has_tab = st_q.run_has_tab || (byte_i == twlc_pkg::CH_TAB);
        end else begin
          // Run closed by a non-blank byte: collapse it, then take the byte
          if (fw) begin
            bat.res[0] = twlc_pkg::mk_res(tpos, fch, 1'b0, '0);
            n          = twlc_pkg::CNT_W'(1);
            tpos       = tpos + twlc_pkg::POS_W'(1);
          end
          st_d.in_space_run = 1'b0;
          st_d.run_has_tab  = 1'b0;
          st_d.out_pos      = tpos;
          do_take           = 1'b1;
        end
      end else if (st_q.out_pos >= limit_i) begin
        st_d.halted = 1'b1;
      end else if (ws) begin
        st_d.in_space_run = 1'b1;
        st_d.run_has_tab  = (byte_i == twlc_pkg::CH_TAB);
      end else begin
        do_take = 1'b1;
      end
    end

    // Ordinary byte handling at position tpos
    if (do_take) begin
      if (byte_i == twlc_pkg::CH_LF) begin
        // A line without letters is rewound to the last line mark
        if (!st_q.line_has_letter) begin
          p  = st_q.line_mark;
          lb = 1'b1;
        end else begin
          p  = tpos;
        end
        if (!st_q.prev_line_blank || !lb) begin
          bat.res[n]     = twlc_pkg::mk_res(p, twlc_pkg::CH_LF, 1'b0, '0);
          n              = n + twlc_pkg::CNT_W'(1);
          p              = p + twlc_pkg::POS_W'(1);
          st_d.line_mark = p;
        end
        st_d.out_pos         = p;
        st_d.prev_line_blank = lb;
        st_d.line_blank      = 1'b1;
        st_d.line_has_letter = 1'b0;
      end else if (byte_i != twlc_pkg::CH_CR) begin
        bat.res[n]           = twlc_pkg::mk_res(tpos, byte_i, 1'b0, '0);
        n                    = n + twlc_pkg::CNT_W'(1);
        st_d.out_pos         = tpos + twlc_pkg::POS_W'(1);
        st_d.line_blank      = 1'b0;
        st_d.line_has_letter = st_q.line_has_letter || twlc_pkg::is_letter(byte_i);
      end
    end

    bat.cnt = n;
    batch_o = bat;
  end

endmodule
`default_nettype wire

FILE: hdl/twlc_res_buf.sv
// Result register holding the writes of one byte and handing them out in order.
`default_nettype none
module twlc_res_buf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          offer_i,
  input  wire twlc_pkg::batch_t              batch_i,
  output logic                               load_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [twlc_pkg::POS_W-1:0]         write_addr_o,
  output logic [twlc_pkg::BYTE_W-1:0]        write_byte_o,
  output logic                               last_o,
  output logic                               done_res_o,
  output logic [twlc_pkg::POS_W-1:0]         text_length_o
);

  twlc_pkg::res_t               res_q [twlc_pkg::MAX_RES];
  logic [twlc_pkg::CNT_W-1:0]   rem_q;
  logic [twlc_pkg::IDX_W-1:0]   idx_q;
  logic                         out_fire;
  twlc_pkg::res_t               cur;

  assign out_valid_o = (rem_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;
  // Free when empty or when the final write of the batch leaves now
  assign load_o      = offer_i &&
                       ((rem_q == '0) || ((rem_q == twlc_pkg::CNT_W'(1)) && !out_stall_i));

  // Remaining count and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
    end else if (load_o) begin
      rem_q <= batch_i.cnt;
      idx_q <= '0;
    end else if (out_fire) begin
      rem_q <= rem_q - twlc_pkg::CNT_W'(1);
      idx_q <= idx_q + twlc_pkg::IDX_W'(1);
    end
  end

  // Write payload storage
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      for (int i = 0; i < twlc_pkg::MAX_RES; i++) begin
        res_q[i] <= batch_i.res[i];
      end
    end
  end

  // Current write on the output
  always_comb begin
    cur           = res_q[idx_q];
    write_addr_o  = cur.addr;
    write_byte_o  = cur.data;
    done_res_o    = cur.done;
    text_length_o = cur.len;
    last_o        = (rem_q == twlc_pkg::CNT_W'(1));
  end

endmodule
`default_nettype wire

FILE: hdl/text_whitespace_line_cleaner.sv
// Top level of the whitespace and line cleaner: input register, limit register, assembly.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / text_byte_i) takes one text byte per
//   request; a zero byte ends the text. Output channel (out_valid_o / out_stall_i)
//   delivers addressed buffer writes: write_addr_o, write_byte_o, last_o on the
//   final write of a byte, done_res_o and text_length_o on terminator writes.
//   The limit register is written through cfg_valid_i / cfg_ready_o /
//   cfg_out_limit_i; ready is always high. Write it only between texts.
// Timing:
//   A byte's first write appears after the byte passes the input register and
//   then the result register. Text whose bytes make zero or one write each
//   streams at one byte per cycle while out_stall_i is low. A byte that makes k
//   writes (k up to 5 for the end-of-text byte) holds the result register until
//   its last write leaves, and input stalls once the next byte is waiting.
// Reset:
//   The limit returns to 4096 and all scanning state clears; after an
//   end-of-text byte the scanning state clears itself the same way.
// Stall:
//   A stalled write holds unchanged; one more byte waits in the input register.
`default_nettype none
module text_whitespace_line_cleaner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input byte channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [twlc_pkg::BYTE_W-1:0]   text_byte_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [twlc_pkg::POS_W-1:0]         write_addr_o,
  output logic [twlc_pkg::BYTE_W-1:0]        write_byte_o,
  output logic                               last_o,
  output logic                               done_res_o,
  output logic [twlc_pkg::POS_W-1:0]         text_length_o,
  // limit register write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [twlc_pkg::POS_W-1:0]    cfg_out_limit_i
);

  logic                         in_valid_q;
  logic [twlc_pkg::BYTE_W-1:0]  byte_q;
  logic [twlc_pkg::POS_W-1:0]   out_limit_q;
  logic [twlc_pkg::POS_W-1:0]   eff_limit;
  logic                         load;
  logic                         in_fire;
  twlc_pkg::batch_t             batch;

  assign cfg_ready_o = 1'b1;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= twlc_pkg::POS_W'(twlc_pkg::OUT_DEPTH);
    end else if (cfg_valid_i && cfg_ready_o) begin
      out_limit_q <= cfg_out_limit_i;
    end
  end

  // Limit clamped to the buffer depth
  assign eff_limit = (out_limit_q > twlc_pkg::POS_W'(twlc_pkg::OUT_DEPTH)) ?
                     twlc_pkg::POS_W'(twlc_pkg::OUT_DEPTH) : out_limit_q;

  // Input register: refills in the same cycle it hands its byte on
  assign in_stall_o = in_valid_q && !load;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q <= text_byte_i;
    end
  end

  twlc_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_q),
    .limit_i (eff_limit),
    .load_i  (load),
    .batch_o (batch)
  );

  twlc_res_buf u_res_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .offer_i       (in_valid_q),
    .batch_i       (batch),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_addr_o  (write_addr_o),
    .write_byte_o  (write_byte_o),
    .last_o        (last_o),
    .done_res_o    (done_res_o),
    .text_length_o (text_length_o)
  );

  // Input side stalls only while a byte is actually held
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  // End of text always produces at least the terminator write
  a_nul_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (byte_q == twlc_pkg::CH_NUL)) |-> (batch.cnt != '0))
    else $error("end-of-text byte produced no write");

  // Any other byte produces at most a run flush and one character
  a_byte_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (byte_q != twlc_pkg::CH_NUL)) |-> (batch.cnt <= twlc_pkg::CNT_W'(2)))
    else $error("ordinary byte produced too many writes");

  // A delivered write that is not the last of its byte is followed by another
  a_batch_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("write batch ended without a last marker");

endmodule
`default_nettype wire
